[rtl/kbr_pkg.sv]
// Shared types and constants for the key buffer with typematic repeat.
// Event, result and queue-entry layouts, mode and register codes, reset values.
// No dependencies.
package kbr_pkg;

    localparam logic [2:0] MODE_PRESS   = 3'd0;
    localparam logic [2:0] MODE_RELEASE = 3'd1;
    localparam logic [2:0] MODE_TICK    = 3'd2;
    localparam logic [2:0] MODE_READ    = 3'd3;
    localparam logic [2:0] MODE_MOVE    = 3'd4;
    localparam logic [2:0] MODE_CLICK   = 3'd5;
    localparam logic [2:0] MODE_WHEEL   = 3'd6;

    localparam logic [2:0] REG_REPEAT_DELAY  = 3'd0;
    localparam logic [2:0] REG_REPEAT_PERIOD = 3'd1;
    localparam logic [2:0] REG_CLICK_CODE    = 3'd2;
    localparam logic [2:0] REG_WHEEL_UP      = 3'd3;
    localparam logic [2:0] REG_WHEEL_DOWN    = 3'd4;

    localparam logic [15:0] RST_REPEAT_DELAY  = 16'd500;
    localparam logic [15:0] RST_REPEAT_PERIOD = 16'd92;
    localparam logic [11:0] RST_CLICK_CODE    = 12'd256;
    localparam logic [11:0] RST_WHEEL_UP      = 12'd257;
    localparam logic [11:0] RST_WHEEL_DOWN    = 12'd258;

    // position stored with keyboard entries
    localparam logic [11:0] NO_POS = 12'hFFF;

    typedef struct packed {
        logic [2:0]        mode;
        logic [9:0]        key_id;
        logic [11:0]       key_value;
        logic              extended;
        logic [15:0]       modifiers;
        logic [11:0]       pos_x;
        logic [11:0]       pos_y;
        logic signed [7:0] wheel_amount;
    } t_evt;

    typedef struct packed {
        logic        empty_res;
        logic [11:0] key_out;
        logic [15:0] mods_out;
        logic [11:0] click_x;
        logic [11:0] click_y;
    } t_res;

    // one queued item; ext items occupy two slots (zero prefix, then code)
    typedef struct packed {
        logic        ext;
        logic [11:0] code;
        logic [15:0] mods;
        logic [11:0] x;
        logic [11:0] y;
    } t_entry;

endpackage

[rtl/kbr_evt_if.sv]
// Event channel: valid/ready handshake carrying one key or pointer event.
// Depends on kbr_pkg.
interface kbr_evt_if;
    logic          valid;
    logic          ready;
    kbr_pkg::t_evt data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/kbr_res_if.sv]
// Result channel: valid/ready handshake carrying one read result.
// Depends on kbr_pkg.
interface kbr_res_if;
    logic          valid;
    logic          ready;
    kbr_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/kbr_cfg_if.sv]
// Configuration write channel: valid/ready with register index and data.
// No dependencies.
interface kbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/key_buffer_typematic_repeat.sv]
// Key buffer with typematic repeat: ring queue, repeater, pointer codes.
// Depends on kbr_pkg, kbr_evt_if, kbr_res_if, kbr_cfg_if.
//
// Usage:
//   i_evt carries key presses/releases, timer ticks, reads and pointer
//   events. Every event is handled when it is taken; only a read produces a
//   result, on o_res, which passes first through the registered queue read
//   and then through the output register.
//   Throughput is one event per clock while o_res is not stalled. The
//   queue memory has one write and one registered read port; an extended
//   key is kept as one stored item spanning two slots, so every event needs
//   at most one memory access.
//   When o_res is stalled, one read result waits in the output register and
//   one more in the read stage; i_evt.ready drops only when both are full.
//   i_cfg is always ready; write registers only while the block is idle.
//   Reset (i_rst_n low, synchronous) empties the queue, disarms the
//   repeater, zeroes pointer and click positions and loads register
//   defaults. No clearing pass is needed: the queue starts usable at once.
module key_buffer_typematic_repeat #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbr_evt_if.sink    i_evt,
    kbr_cfg_if.sink    i_cfg,
    kbr_res_if.source  o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_M1 = AW'(QUEUE_DEPTH - 2);

    // configuration
    logic [15:0] r_repeat_delay, r_repeat_period;
    logic [11:0] r_click_code, r_wheel_up, r_wheel_down;

    // queue control
    logic [AW-1:0] r_rd, r_wr, r_cnt, n_wr, n_cnt;
    logic          r_half;

    // repeater and pointer
    logic          r_held, n_held;
    logic [9:0]    r_held_id, n_held_id;
    logic [11:0]   r_held_code, n_held_code;
    logic          r_held_ext, n_held_ext;
    logic [15:0]   r_held_mods, n_held_mods;
    logic [15:0]   r_countdown, n_countdown;
    logic [11:0]   r_ptr_x, r_ptr_y, n_ptr_x, n_ptr_y;
    logic [11:0]   r_last_x, r_last_y;

    // memory and read stage
    kbr_pkg::t_entry r_mem [QUEUE_DEPTH];
    kbr_pkg::t_entry r_rdata;
    kbr_pkg::t_entry w_push_ent;
    logic            w_push;
    logic            w_pop;
    logic            r_s1_v, r_s1_empty, r_pop_second, r_pend;

    // output register
    logic            r_out_v;
    kbr_pkg::t_res   r_out;

    kbr_pkg::t_evt   w_evt;
    logic            w_acc, w_s1_go;
    logic            w_adv, w_half_eff;
    logic [AW-1:0]   w_rd_eff;
    logic            w_key_ok, w_rep_ok, w_held_rep;
    logic            w_pref, w_hit;
    logic [11:0]     w_code, w_x, w_y;
    kbr_pkg::t_res   w_res;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST) ? '0 : p + AW'(1);
    endfunction

    assign w_evt   = i_evt.data;
    assign w_acc   = i_evt.valid && i_evt.ready;
    assign w_s1_go = r_s1_v && (!r_out_v || o_res.ready);

    assign i_evt.ready = !r_s1_v || w_s1_go;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    // settle the head pointer from the previous pop: an ext item advances
    // only after its second slot is taken
    assign w_adv      = r_pend && (!r_rdata.ext || r_pop_second);
    assign w_half_eff = r_pend ? (r_rdata.ext && !r_pop_second) : r_half;
    assign w_rd_eff   = w_adv ? ptr_inc(r_rd) : r_rd;

    // room for a key push of the event or of the held key
    assign w_key_ok   = w_evt.extended ? (r_cnt < LAST_M1) : (r_cnt < LAST);
    assign w_rep_ok   = r_held_ext ? (r_cnt < LAST_M1) : (r_cnt < LAST);
    assign w_held_rep = (r_held_code != '0) && (r_held_ext || r_held_code < r_click_code);

    always_comb begin
        n_held      = r_held;
        n_held_id   = r_held_id;
        n_held_code = r_held_code;
        n_held_ext  = r_held_ext;
        n_held_mods = r_held_mods;
        n_countdown = r_countdown;
        n_ptr_x     = r_ptr_x;
        n_ptr_y     = r_ptr_y;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_push_ent  = '{ext: w_evt.extended, code: w_evt.key_value, mods: w_evt.modifiers,
                        x: kbr_pkg::NO_POS, y: kbr_pkg::NO_POS};
        if (w_acc) begin
            case (w_evt.mode)
                kbr_pkg::MODE_PRESS: begin
                    if (w_evt.key_value != '0) begin
                        w_push = w_key_ok;
                        if (w_evt.extended || w_evt.key_value < r_click_code) begin
                            n_held      = 1'b1;
                            n_held_id   = w_evt.key_id;
                            n_held_code = w_evt.key_value;
                            n_held_ext  = w_evt.extended;
                            n_held_mods = w_evt.modifiers;
                            n_countdown = r_repeat_delay;
                        end
                    end
                end
                kbr_pkg::MODE_RELEASE: begin
                    if (r_held && w_evt.key_id == r_held_id)
                        n_held = 1'b0;
                end
                kbr_pkg::MODE_TICK: begin
                    if (r_held) begin
                        if (r_countdown > 16'd1) begin
                            n_countdown = r_countdown - 16'd1;
                        end else if (!w_held_rep) begin
                            n_held = 1'b0;
                        end else begin
                            w_push      = w_rep_ok;
                            w_push_ent  = '{ext: r_held_ext, code: r_held_code,
                                            mods: r_held_mods,
                                            x: kbr_pkg::NO_POS, y: kbr_pkg::NO_POS};
                            n_countdown = r_repeat_period;
                        end
                    end
                end
                kbr_pkg::MODE_READ: begin
                    w_pop = (r_cnt != '0);
                end
                kbr_pkg::MODE_MOVE: begin
                    n_ptr_x = w_evt.pos_x;
                    n_ptr_y = w_evt.pos_y;
                end
                kbr_pkg::MODE_CLICK: begin
                    n_ptr_x    = w_evt.pos_x;
                    n_ptr_y    = w_evt.pos_y;
                    w_push     = (r_cnt < LAST);
                    w_push_ent = '{ext: 1'b0, code: r_click_code, mods: 16'd0,
                                   x: w_evt.pos_x, y: w_evt.pos_y};
                end
                kbr_pkg::MODE_WHEEL: begin
                    if (w_evt.wheel_amount != 8'sd0) begin
                        w_push     = (r_cnt < LAST);
                        w_push_ent = '{ext: 1'b0,
                                       code: w_evt.wheel_amount[7] ? r_wheel_down : r_wheel_up,
                                       mods: 16'd0, x: r_ptr_x, y: r_ptr_y};
                    end
                end
                default: begin
                end
            endcase
        end
        n_wr  = w_push ? ptr_inc(r_wr) : r_wr;
        if (w_push)
            n_cnt = r_cnt + (w_push_ent.ext ? AW'(2) : AW'(1));
        else if (w_pop)
            n_cnt = r_cnt - AW'(1);
        else
            n_cnt = r_cnt;
    end

    // queue storage: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wr] <= w_push_ent;
        if (w_pop)
            r_rdata <= r_mem[w_rd_eff];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_delay  <= kbr_pkg::RST_REPEAT_DELAY;
            r_repeat_period <= kbr_pkg::RST_REPEAT_PERIOD;
            r_click_code    <= kbr_pkg::RST_CLICK_CODE;
            r_wheel_up      <= kbr_pkg::RST_WHEEL_UP;
            r_wheel_down    <= kbr_pkg::RST_WHEEL_DOWN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                kbr_pkg::REG_REPEAT_DELAY:  r_repeat_delay  <= i_cfg.data;
                kbr_pkg::REG_REPEAT_PERIOD: r_repeat_period <= i_cfg.data;
                kbr_pkg::REG_CLICK_CODE:    r_click_code    <= i_cfg.data[11:0];
                kbr_pkg::REG_WHEEL_UP:      r_wheel_up      <= i_cfg.data[11:0];
                kbr_pkg::REG_WHEEL_DOWN:    r_wheel_down    <= i_cfg.data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_wr        <= '0;
            r_cnt       <= '0;
            r_half      <= 1'b0;
            r_pend      <= 1'b0;
            r_held      <= 1'b0;
            r_held_id   <= '0;
            r_held_code <= '0;
            r_held_ext  <= 1'b0;
            r_held_mods <= '0;
            r_countdown <= '0;
            r_ptr_x     <= '0;
            r_ptr_y     <= '0;
        end else begin
            r_rd        <= w_rd_eff;
            r_wr        <= n_wr;
            r_cnt       <= n_cnt;
            r_half      <= w_half_eff;
            r_pend      <= w_pop;
            r_held      <= n_held;
            r_held_id   <= n_held_id;
            r_held_code <= n_held_code;
            r_held_ext  <= n_held_ext;
            r_held_mods <= n_held_mods;
            r_countdown <= n_countdown;
            r_ptr_x     <= n_ptr_x;
            r_ptr_y     <= n_ptr_y;
        end
    end

    // read stage: hold the popped slot until the output register frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_acc && w_evt.mode == kbr_pkg::MODE_READ) begin
            r_s1_v <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_evt.mode == kbr_pkg::MODE_READ) begin
            r_s1_empty   <= (r_cnt == '0);
            r_pop_second <= w_half_eff;
        end
    end

    // first slot of an ext item reads as the zero prefix without position
    assign w_pref = r_rdata.ext && !r_pop_second;
    assign w_code = w_pref ? 12'd0 : r_rdata.code;
    assign w_x    = w_pref ? kbr_pkg::NO_POS : r_rdata.x;
    assign w_y    = w_pref ? kbr_pkg::NO_POS : r_rdata.y;
    assign w_hit  = !r_s1_empty && (w_code == r_click_code);

    always_comb begin
        w_res.empty_res = r_s1_empty;
        w_res.key_out   = r_s1_empty ? 12'd0 : w_code;
        w_res.mods_out  = r_s1_empty ? 16'd0 : r_rdata.mods;
        w_res.click_x   = w_hit ? w_x : r_last_x;
        w_res.click_y   = w_hit ? w_y : r_last_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (w_s1_go) begin
            r_out_v  <= 1'b1;
            r_last_x <= w_res.click_x;
            r_last_y <= w_res.click_y;
        end else if (o_res.ready) begin
            r_out_v  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go)
            r_out <= w_res;
    end

`ifndef SYNTHESIS
    // a pending head update always has its popped slot in the read stage
    a_pend_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_s1_v && !r_s1_empty))
        else $error("pending pop without read-stage data");

    // after a prefix is taken its code slot is still queued
    a_half_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_half_eff |-> (r_cnt != '0))
        else $error("prefix taken but queue empty");

    // an empty queue has its settled head at the write pointer
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (w_rd_eff == r_wr))
        else $error("empty count with pointers apart");

    // a read of an empty queue reports empty in the read stage
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_evt.mode == kbr_pkg::MODE_READ && r_cnt == '0)
            |=> (r_s1_v && r_s1_empty))
        else $error("empty read not flagged");
`endif

endmodule
